// File: src/twcc_pkg.sv
// ----------------------------------------------------------------------------
// twcc_pkg: shared types and constants for the text window cursor control
// Request and response payloads, action codes, register indexes and the
// configuration reset values.
// ----------------------------------------------------------------------------
package twcc_pkg;

   // Tab stop spacing in columns
   localparam int TAB_STOP = 8;

   // Most responses one request can cause
   localparam int MAX_RSP = 3;

   // Configuration reset values
   localparam logic [7:0] COLS_RESET      = 8'd80;
   localparam logic [5:0] ROWS_RESET      = 6'd25;
   localparam logic       CRLF_NRM_RESET  = 1'b1;
   localparam logic       CRLF_ECHO_RESET = 1'b1;

   // Control characters
   localparam logic [7:0] CHR_BEL = 8'd7;
   localparam logic [7:0] CHR_BS  = 8'd8;
   localparam logic [7:0] CHR_TAB = 8'd9;
   localparam logic [7:0] CHR_LF  = 8'd10;
   localparam logic [7:0] CHR_CR  = 8'd13;
   localparam logic [7:0] CHR_SPACE = 8'd32;
   localparam logic [7:0] CHR_HIGH  = 8'd128;

   typedef enum logic [2:0] {
      ACT_WRITE  = 3'd0,
      ACT_MOVE   = 3'd1,
      ACT_SCROLL = 3'd2,
      ACT_CLEAR  = 3'd3,
      ACT_BELL   = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      CSR_WINDOW_COLUMNS = 2'd0,
      CSR_WINDOW_ROWS    = 2'd1,
      CSR_CRLF_NORMAL    = 2'd2,
      CSR_CRLF_ECHO      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       from_echo;
   } req_type;

   typedef struct packed {
      action_type action;
      logic [7:0] glyph;
      logic [5:0] at_row;
      logic [7:0] at_col;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] window_columns;
      logic [5:0] window_rows;
      logic       crlf_normal;
      logic       crlf_echo;
   } cfg_type;

   // Outcome of one request: response list, count and the new cursor
   typedef struct packed {
      rsp_type [MAX_RSP-1:0] rsp;
      logic [1:0]            count;
      logic [5:0]            row;
      logic [7:0]            col;
   } step_type;

endpackage

// File: src/twcc_step.sv
// ----------------------------------------------------------------------------
// twcc_step: character interpreter
// Works out, for one request and the current cursor, the list of display
// commands and the cursor position that follows.
// ----------------------------------------------------------------------------
module twcc_step
   import twcc_pkg::*;
(
   input  req_type    req,
   input  cfg_type    cfg,
   input  logic [5:0] cur_row,
   input  logic [7:0] cur_col,
   output step_type   step
);

   function automatic rsp_type mk(input action_type act, input logic [7:0] g,
                                  input logic [5:0] r, input logic [7:0] c);
      rsp_type x;
      x.action = act;
      x.glyph  = g;
      x.at_row = r;
      x.at_col = c;
      x.last   = 1'b0;
      return x;
   endfunction

   logic [5:0]  bottom;
   logic        at_bottom;
   action_type  ld_act;
   logic        expand;
   logic [8:0]  next_col;
   logic [8:0]  tab_sum;
   logic [8:0]  tab_col;
   logic        wrap_write;
   logic        wrap_tab;
   logic [5:0]  row_down;
   rsp_type     r0, r1, r2;
   logic [1:0]  n;
   logic [5:0]  row_n;
   logic [7:0]  col_n;

   // Bottom row, a zero row count acting as one row
   assign bottom    = (cfg.window_rows == 6'd0) ? 6'd0 : cfg.window_rows - 6'd1;
   assign at_bottom = (cur_row >= bottom);
   assign ld_act    = (cfg.window_rows > 6'd1) ? ACT_SCROLL : ACT_CLEAR;
   assign row_down  = cur_row + 6'd1;
   assign expand    = req.from_echo ? cfg.crlf_echo : cfg.crlf_normal;

   // Column after a printable and after a tab, with their wrap tests
   assign next_col   = {1'b0, cur_col} + 9'd1;
   assign tab_sum    = {1'b0, cur_col} + 9'(TAB_STOP);
   assign tab_col    = tab_sum - (tab_sum % 9'(TAB_STOP));
   assign wrap_write = (next_col >= {1'b0, cfg.window_columns});
   assign wrap_tab   = (tab_col >= {1'b0, cfg.window_columns});

   // Command list and new cursor
   always_comb begin
      r0    = mk(ACT_MOVE, 8'd0, 6'd0, 8'd0);
      r1    = r0;
      r2    = r0;
      n     = 2'd0;
      row_n = cur_row;
      col_n = cur_col;
      if ((req.char_code == CHR_CR || req.char_code == CHR_LF) && expand) begin
         // CR then LF
         col_n = 8'd0;
         r0    = mk(ACT_MOVE, 8'd0, cur_row, 8'd0);
         if (at_bottom) begin
            r1 = mk(ld_act, 8'd0, 6'd0, 8'd0);
            r2 = mk(ACT_MOVE, 8'd0, cur_row, 8'd0);
            n  = 2'd3;
         end else begin
            row_n = row_down;
            r1    = mk(ACT_MOVE, 8'd0, row_down, 8'd0);
            n     = 2'd2;
         end
      end else if (req.char_code >= CHR_HIGH) begin
         n = 2'd0;
      end else if (req.char_code >= CHR_SPACE) begin
         // Printable: write, advance, wrap
         r0 = mk(ACT_WRITE, req.char_code, cur_row, cur_col);
         n  = 2'd1;
         if (wrap_write) begin
            col_n = 8'd0;
            if (at_bottom) begin
               r1 = mk(ld_act, 8'd0, 6'd0, 8'd0);
               n  = 2'd2;
            end else begin
               row_n = row_down;
            end
         end else begin
            col_n = next_col[7:0];
         end
      end else begin
         case (req.char_code)
            CHR_CR: begin
               col_n = 8'd0;
               r0    = mk(ACT_MOVE, 8'd0, cur_row, 8'd0);
               n     = 2'd1;
            end
            CHR_LF: begin
               if (at_bottom) begin
                  r0 = mk(ld_act, 8'd0, 6'd0, 8'd0);
                  r1 = mk(ACT_MOVE, 8'd0, cur_row, cur_col);
                  n  = 2'd2;
               end else begin
                  row_n = row_down;
                  r0    = mk(ACT_MOVE, 8'd0, row_down, cur_col);
                  n     = 2'd1;
               end
            end
            CHR_BEL: begin
               r0 = mk(ACT_BELL, 8'd0, 6'd0, 8'd0);
               n  = 2'd1;
            end
            CHR_BS: begin
               col_n = (cur_col != 8'd0) ? cur_col - 8'd1 : 8'd0;
               r0    = mk(ACT_MOVE, 8'd0, cur_row, col_n);
               n     = 2'd1;
            end
            CHR_TAB: begin
               if (wrap_tab) begin
                  col_n = 8'd0;
                  if (at_bottom) begin
                     r0 = mk(ld_act, 8'd0, 6'd0, 8'd0);
                     r1 = mk(ACT_MOVE, 8'd0, cur_row, 8'd0);
                     n  = 2'd2;
                  end else begin
                     row_n = row_down;
                     r0    = mk(ACT_MOVE, 8'd0, row_down, 8'd0);
                     n     = 2'd1;
                  end
               end else begin
                  col_n = tab_col[7:0];
                  r0    = mk(ACT_MOVE, 8'd0, cur_row, tab_col[7:0]);
                  n     = 2'd1;
               end
            end
            default: begin
               n = 2'd0;
            end
         endcase
      end
      // Flag the final command
      r0.last = (n == 2'd1);
      r1.last = (n == 2'd2);
      r2.last = (n == 2'd3);
   end

   assign step.rsp   = {r2, r1, r0};
   assign step.count = n;
   assign step.row   = row_n;
   assign step.col   = col_n;

endmodule

// File: src/twcc_rsp_queue.sv
// ----------------------------------------------------------------------------
// twcc_rsp_queue: response shift buffer
// Holds the commands of one request and hands them out one per cycle while
// rsp_ready is high; reports when it can take the next request's list.
// ----------------------------------------------------------------------------
module twcc_rsp_queue
   import twcc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     load,
   input  step_type load_step,
   output logic     free,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp
);

   rsp_type    buf_ff [MAX_RSP];
   rsp_type    buf_in [MAX_RSP];
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic       pop;

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp       = buf_ff[0];
   assign pop       = rsp_valid && rsp_ready;
   assign free      = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_ready);

   // Shift out on a taken response, reload from a new request
   always_comb begin
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      if (pop) begin
         buf_in[0] = buf_ff[1];
         buf_in[1] = buf_ff[2];
         cnt_in    = cnt_ff - 2'd1;
      end
      if (load) begin
         for (int i = 0; i < MAX_RSP; i++) begin
            buf_in[i] = load_step.rsp[i];
         end
         cnt_in = load_step.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      buf_ff <= buf_in;
   end

endmodule

// File: src/text_window_cursor_control_unit.sv
// ----------------------------------------------------------------------------
// text_window_cursor_control_unit: text window cursor control, top level
// Request path: input register, response buffer. Throughput: one request per
// cycle for one response or none while rsp_ready is high; a request with two
// or three responses holds the next one until its last response is taken (one
// response port). Reset clears the cursor to row 0, column 0, empties the
// buffers and loads the register defaults (80 columns, 25 rows, CRLF on for both).
// ----------------------------------------------------------------------------
module text_window_cursor_control_unit
   import twcc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   logic       in_valid_ff, in_valid_in;
   req_type    in_req_ff, in_req_in;
   cfg_type    cfg_ff, cfg_in;
   logic [5:0] row_ff, row_in;
   logic [7:0] col_ff, col_in;
   step_type   step;
   logic       q_free;
   logic       process;

   // Input register, drained when the buffer can take the result list
   assign process   = in_valid_ff && q_free;
   assign req_ready = !in_valid_ff || process;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_req_in   = in_req_ff;
      if (process) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_req_in   = req_data;
      end
   end

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_WINDOW_COLUMNS: cfg_in.window_columns = csr_wdata;
            CSR_WINDOW_ROWS:    cfg_in.window_rows    = csr_wdata[5:0];
            CSR_CRLF_NORMAL:    cfg_in.crlf_normal    = csr_wdata[0];
            CSR_CRLF_ECHO:      cfg_in.crlf_echo      = csr_wdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // Cursor follows each processed request
   assign row_in = process ? step.row : row_ff;
   assign col_in = process ? step.col : col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff           <= 1'b0;
         row_ff                <= 6'd0;
         col_ff                <= 8'd0;
         cfg_ff.window_columns <= COLS_RESET;
         cfg_ff.window_rows    <= ROWS_RESET;
         cfg_ff.crlf_normal    <= CRLF_NRM_RESET;
         cfg_ff.crlf_echo      <= CRLF_ECHO_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         cfg_ff      <= cfg_in;
      end
      in_req_ff <= in_req_in;
   end

   twcc_step u_step (
      .req     (in_req_ff),
      .cfg     (cfg_ff),
      .cur_row (row_ff),
      .cur_col (col_ff),
      .step    (step)
   );

   twcc_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (process),
      .load_step (step),
      .free      (q_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp_data)
   );

endmodule

// File: src/twcc_checker.sv
// ----------------------------------------------------------------------------
// twcc_checker: port-level checks for the cursor control unit
// Watches the response channel for ordering of command groups and handshake
// behavior; attached to the top level by bind.
// ----------------------------------------------------------------------------
module twcc_checker
   import twcc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // Nothing offered right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // Rest of a command group follows without a gap
   a_group_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last |=> rsp_valid)
      else $error("gap inside a command group");

   // Bell is always the final command of its group
   a_bell_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.action == ACT_BELL |-> rsp_data.last)
      else $error("bell not final");

   // A move that is not final goes to column 0, as the carriage return of a CRLF pair does
   a_move_cr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.action == ACT_MOVE && !rsp_data.last
      |-> rsp_data.at_col == 8'd0)
      else $error("leading move not at column 0");

endmodule

bind text_window_cursor_control_unit twcc_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
